// ===== hdl/tpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpcf_pkg: shared constants and types of the three-pad cluster finder
// Geometry, field widths, register indexes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tpcf_pkg;

    // Geometry and sample width
    localparam int TIME_BINS    = 30;
    localparam int PADS_PER_ROW = 144;
    localparam int ADC_BITS     = 10;
    localparam int MAX_RESULTS  = 30;
    localparam int NUM_RES      = (TIME_BINS < MAX_RESULTS) ? TIME_BINS : MAX_RESULTS;

    // Derived widths
    localparam int TB_AW  = (TIME_BINS > 1) ? $clog2(TIME_BINS) : 1;
    localparam int ACC_W  = ADC_BITS + TB_AW;
    localparam int CADC_W = ADC_BITS + 2;

    // Port field widths
    localparam int DET_W  = 10;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 8;
    localparam int TB_W   = 5;
    localparam int ADC_W  = 10;
    localparam int CLADC_W = 12;
    localparam int PSUM_W = 15;
    localparam int CSUM_W = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // Saturation limits
    localparam logic [PSUM_W-1:0]  PSUM_MAX  = '1;
    localparam logic [CLADC_W-1:0] CLADC_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_TH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_TH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_TH = 2'd2;

    // Register reset values
    localparam logic [14:0] CENTER_TH_RST   = 15'd310;
    localparam logic [16:0] CLUSTER_TH_RST  = 17'd910;
    localparam logic [14:0] NEIGHBOR_TH_RST = 15'd310;

    // Controller to datapath
    typedef struct packed {
        logic             accept;     // input item taken this cycle
        logic             sum_rd;     // read issued for the pad sum sweep
        logic             sum_store;  // store the swept sum of the newest pad
        logic [TB_AW-1:0] rd_addr;    // time bin read from all three banks
        logic             out_load;   // load the result register
        logic             out_last;   // loaded result ends the cluster
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_last;   // offered item is the last time bin of a pad
        logic pass;      // centre pad passes the cluster test
        logic out_busy;  // result register full and not taken this cycle
    } t_dp_sts;

endpackage

// ===== hdl/tpcf_ram.sv =====
// ----------------------------------------------------------------------------
// tpcf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tpcf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 30
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tpcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpcf_ctrl: sequencer of the three-pad cluster finder
// Takes samples, sweeps the newest pad for its time sum, runs the cluster
// test and steps the result emission through the time bins.
// ----------------------------------------------------------------------------
module tpcf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_in_ready,
    input  tpcf_pkg::t_dp_sts i_sts,
    output tpcf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_END,
        ST_STORE,
        ST_TEST,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    t_state                     r_state;
    logic [tpcf_pkg::TB_AW-1:0] r_cnt;
    logic                       w_cnt_sum_end;
    logic                       w_cnt_res_end;

    assign w_cnt_sum_end = (r_cnt == tpcf_pkg::TB_AW'(tpcf_pkg::TIME_BINS - 1));
    assign w_cnt_res_end = (r_cnt == tpcf_pkg::TB_AW'(tpcf_pkg::NUM_RES - 1));

    // Commands decoded from state
    always_comb begin
        o_in_ready        = (r_state == ST_IDLE);
        o_cmd.accept      = (r_state == ST_IDLE) && i_valid;
        o_cmd.sum_rd      = (r_state == ST_SUM);
        o_cmd.sum_store   = (r_state == ST_STORE);
        o_cmd.rd_addr     = r_cnt;
        o_cmd.out_load    = (r_state == ST_EMIT_LD);
        o_cmd.out_last    = w_cnt_res_end;
    end

    // State and bin counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && i_sts.in_last) begin
                        r_state <= ST_SUM;
                        r_cnt   <= '0;
                    end
                end
                ST_SUM: begin
                    if (w_cnt_sum_end) begin
                        r_state <= ST_SUM_END;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SUM_END: begin
                    r_state <= ST_STORE;
                end
                ST_STORE: begin
                    r_state <= ST_TEST;
                end
                ST_TEST: begin
                    r_cnt <= '0;
                    if (i_sts.pass) begin
                        r_state <= ST_EMIT_RD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT_RD: begin
                    // hold the read until the result register frees up
                    if (!i_sts.out_busy) begin
                        r_state <= ST_EMIT_LD;
                    end
                end
                ST_EMIT_LD: begin
                    if (w_cnt_res_end) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= ST_EMIT_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/tpcf_dp.sv =====
// ----------------------------------------------------------------------------
// tpcf_dp: datapath of the three-pad cluster finder
// Three rotating sample banks with per-bin valid bits, pad sums, the
// configuration registers, the cluster test and the result register.
// ----------------------------------------------------------------------------
module tpcf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [tpcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tpcf_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // input fields
    input  logic [tpcf_pkg::DET_W-1:0]          i_detector,
    input  logic [tpcf_pkg::ROW_W-1:0]          i_pad_row,
    input  logic [tpcf_pkg::COL_W-1:0]          i_pad_col,
    input  logic [tpcf_pkg::TB_W-1:0]           i_time_bin,
    input  logic [tpcf_pkg::ADC_W-1:0]          i_adc,
    // result channel
    output logic                                o_valid,
    input  logic                                i_out_ready,
    output logic [tpcf_pkg::DET_W-1:0]          o_out_detector,
    output logic [tpcf_pkg::ROW_W-1:0]          o_out_row,
    output logic [tpcf_pkg::COL_W-1:0]          o_center_col,
    output logic [tpcf_pkg::TB_W-1:0]           o_out_time_bin,
    output logic [tpcf_pkg::CLADC_W-1:0]        o_cluster_adc,
    output logic [tpcf_pkg::PSUM_W-1:0]         o_center_sum,
    output logic [tpcf_pkg::CSUM_W-1:0]         o_cluster_sum,
    output logic                                o_last,
    // control
    input  tpcf_pkg::t_dp_cmd                   i_cmd,
    output tpcf_pkg::t_dp_sts                   o_sts
);

    // Configuration registers
    logic [14:0] r_cth;
    logic [16:0] r_kth;
    logic [14:0] r_nth;

    // Window state
    logic [1:0]                          r_fill;
    logic [1:0]                          r_newest;
    logic [tpcf_pkg::DET_W-1:0]          r_det;
    logic [tpcf_pkg::ROW_W-1:0]          r_row;
    logic [tpcf_pkg::COL_W-1:0]          r_col;
    logic [tpcf_pkg::PSUM_W-1:0]         r_sum [3];
    logic [tpcf_pkg::TIME_BINS-1:0]      r_vld [3];

    // Sweep and read pipeline
    logic [tpcf_pkg::ACC_W-1:0]          r_acc;
    logic                                r_sum_q;
    logic [2:0]                          r_rd_vld;
    logic [tpcf_pkg::TB_AW-1:0]          r_rd_addr_q;

    // Result register
    logic                                r_ov;
    logic [tpcf_pkg::DET_W-1:0]          r_o_det;
    logic [tpcf_pkg::ROW_W-1:0]          r_o_row;
    logic [tpcf_pkg::COL_W-1:0]          r_o_col;
    logic [tpcf_pkg::TB_W-1:0]           r_o_tb;
    logic [tpcf_pkg::CLADC_W-1:0]        r_o_cadc;
    logic [tpcf_pkg::PSUM_W-1:0]         r_o_csum;
    logic [tpcf_pkg::CSUM_W-1:0]         r_o_ksum;
    logic                                r_o_last;

    // Combinational
    logic                                w_in_range;
    logic                                w_pad_start;
    logic                                w_shift;
    logic [1:0]                          w_next_bank;
    logic [1:0]                          w_mid_bank;
    logic [1:0]                          w_old_bank;
    logic [1:0]                          w_wr_bank;
    logic [tpcf_pkg::TB_AW-1:0]          w_tb_addr;
    logic [tpcf_pkg::ADC_BITS-1:0]       w_adc;
    logic [tpcf_pkg::ADC_BITS-1:0]       w_rdata [3];
    logic [tpcf_pkg::ADC_BITS-1:0]       w_samp  [3];
    logic [tpcf_pkg::ACC_W-1:0]          n_acc;
    logic [tpcf_pkg::PSUM_W-1:0]         w_acc_sat;
    logic [tpcf_pkg::PSUM_W-1:0]         w_l;
    logic [tpcf_pkg::PSUM_W-1:0]         w_c;
    logic [tpcf_pkg::PSUM_W-1:0]         w_r;
    logic [tpcf_pkg::CSUM_W-1:0]         w_clu;
    logic                                w_col_ok;
    logic [tpcf_pkg::CADC_W-1:0]         w_cadc;
    logic [tpcf_pkg::CLADC_W-1:0]        w_cadc_sat;

    // Sample decode and window shift decision
    always_comb begin
        w_in_range  = ({1'b0, i_time_bin} < 6'(tpcf_pkg::TIME_BINS));
        w_pad_start = (i_time_bin == '0);
        w_shift     = (r_fill != 2'd0) && (i_detector == r_det) && (i_pad_row == r_row) &&
                      ({1'b0, i_pad_col} == ({1'b0, r_col} + 9'd1));
        w_next_bank = (r_newest == 2'd2) ? 2'd0 : r_newest + 2'd1;
        w_mid_bank  = (r_newest == 2'd0) ? 2'd2 : r_newest - 2'd1;
        w_old_bank  = (w_mid_bank == 2'd0) ? 2'd2 : w_mid_bank - 2'd1;
        w_wr_bank   = (w_pad_start && w_shift) ? w_next_bank : r_newest;
        w_tb_addr   = tpcf_pkg::TB_AW'(i_time_bin);
        w_adc       = tpcf_pkg::ADC_BITS'(i_adc);
    end

    // Sample banks, one per pad slot, rotated by r_newest
    for (genvar b = 0; b < 3; b++) begin : g_bank
        tpcf_ram #(
            .WIDTH (tpcf_pkg::ADC_BITS),
            .DEPTH (tpcf_pkg::TIME_BINS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.accept && w_in_range && (w_wr_bank == 2'(b))),
            .i_waddr (w_tb_addr),
            .i_wdata (w_adc),
            .i_raddr (i_cmd.rd_addr),
            .o_rdata (w_rdata[b])
        );
        // bins never written since pad start read as zero
        assign w_samp[b] = r_rd_vld[b] ? w_rdata[b] : '0;
    end

    // Sweep accumulator and saturation of the pad sum
    always_comb begin
        n_acc     = r_acc + tpcf_pkg::ACC_W'(w_samp[r_newest]);
        w_acc_sat = (32'(r_acc) > 32'(tpcf_pkg::PSUM_MAX)) ? tpcf_pkg::PSUM_MAX
                                                             : tpcf_pkg::PSUM_W'(r_acc);
    end

    // Cluster test on the three pad sums (three 15-bit sums never exceed 17 bits)
    always_comb begin
        w_r      = r_sum[r_newest];
        w_c      = r_sum[w_mid_bank];
        w_l      = r_sum[w_old_bank];
        w_clu    = tpcf_pkg::CSUM_W'(w_l) + tpcf_pkg::CSUM_W'(w_c) + tpcf_pkg::CSUM_W'(w_r);
        // centre column from 1 to PADS_PER_ROW-2
        w_col_ok = ({1'b0, r_col} >= 9'd2) &&
                   ({1'b0, r_col} <= 9'(tpcf_pkg::PADS_PER_ROW - 1));
        o_sts.pass = (r_fill == 2'd3) && w_col_ok &&
                     (w_c >= w_l) && (w_c >= w_r) &&
                     (w_c >= r_cth) && (w_clu >= r_kth) &&
                     ((w_l >= r_nth) || (w_r >= r_nth));
        o_sts.in_last  = ({1'b0, i_time_bin} == 6'(tpcf_pkg::TIME_BINS - 1));
        o_sts.out_busy = r_ov && !i_out_ready;
    end

    // Three-pad ADC of one bin, saturated
    always_comb begin
        w_cadc = tpcf_pkg::CADC_W'(w_samp[0]) + tpcf_pkg::CADC_W'(w_samp[1]) +
                 tpcf_pkg::CADC_W'(w_samp[2]);
        w_cadc_sat = (32'(w_cadc) > 32'(tpcf_pkg::CLADC_MAX)) ? tpcf_pkg::CLADC_MAX
                                                                : tpcf_pkg::CLADC_W'(w_cadc);
    end

    // Control state: config, window bookkeeping, valid bits, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cth    <= tpcf_pkg::CENTER_TH_RST;
            r_kth    <= tpcf_pkg::CLUSTER_TH_RST;
            r_nth    <= tpcf_pkg::NEIGHBOR_TH_RST;
            r_fill   <= 2'd0;
            r_newest <= 2'd0;
            r_det    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_sum    <= '{default: '0};
            r_vld    <= '{default: '0};
            r_sum_q  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tpcf_pkg::REG_CENTER_TH:   r_cth <= i_cfg_data[14:0];
                    tpcf_pkg::REG_CLUSTER_TH:  r_kth <= i_cfg_data[16:0];
                    tpcf_pkg::REG_NEIGHBOR_TH: r_nth <= i_cfg_data[14:0];
                    default: ;
                endcase
            end

            if (i_cmd.accept && w_in_range) begin
                if (w_pad_start) begin
                    // new pad: shift the window or restart it
                    if (w_shift) begin
                        r_newest <= w_next_bank;
                        if (r_fill != 2'd3) begin
                            r_fill <= r_fill + 2'd1;
                        end
                    end else begin
                        r_fill <= 2'd1;
                    end
                    r_det               <= i_detector;
                    r_row               <= i_pad_row;
                    r_col               <= i_pad_col;
                    r_sum[w_wr_bank]    <= '0;
                    r_vld[w_wr_bank]    <= tpcf_pkg::TIME_BINS'(1);
                end else begin
                    r_vld[r_newest][w_tb_addr] <= 1'b1;
                end
            end

            if (i_cmd.sum_store) begin
                r_sum[r_newest] <= w_acc_sat;
            end

            r_sum_q <= i_cmd.sum_rd;

            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload: read pipeline, accumulator, result register
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 3; b++) begin
            r_rd_vld[b] <= r_vld[b][i_cmd.rd_addr];
        end
        r_rd_addr_q <= i_cmd.rd_addr;

        if (i_cmd.accept) begin
            r_acc <= '0;
        end else if (r_sum_q) begin
            r_acc <= n_acc;
        end

        if (i_cmd.out_load) begin
            r_o_det  <= r_det;
            r_o_row  <= r_row;
            r_o_col  <= r_col - 1'b1;
            r_o_tb   <= tpcf_pkg::TB_W'(r_rd_addr_q);
            r_o_cadc <= w_cadc_sat;
            r_o_csum <= w_c;
            r_o_ksum <= w_clu;
            r_o_last <= i_cmd.out_last;
        end
    end

    assign o_valid        = r_ov;
    assign o_out_detector = r_o_det;
    assign o_out_row      = r_o_row;
    assign o_center_col   = r_o_col;
    assign o_out_time_bin = r_o_tb;
    assign o_cluster_adc  = r_o_cadc;
    assign o_center_sum   = r_o_csum;
    assign o_cluster_sum  = r_o_ksum;
    assign o_last         = r_o_last;

endmodule

// ===== hdl/three_pad_cluster_finder.sv =====
// ----------------------------------------------------------------------------
// three_pad_cluster_finder: three-pad peak cluster finder
// Keeps the last three contiguous pads of a detector row and emits the
// per-bin three-pad ADC of every pad that forms a cluster centre.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one ADC sample per item; pads
//   come in rising column order, each with time bins 0 to 29.
//   Output channel (o_valid / i_ready) carries one cluster value per time
//   bin of a found cluster, o_last set on the final one.
//   Config port (i_cfg_we, i_cfg_index, i_cfg_data) writes a threshold;
//   write only while the block is idle.
//   Throughput: a sample that is not the last bin of a pad is taken every
//   cycle. The last bin starts a read sweep of the newest pad's bank for its
//   time sum; the SUM_END, STORE and TEST states then finish, store and test
//   that sum, and the input stays held through them all.
//   A found cluster emits its 30 values, each by a bank read and then a
//   result register load, after which input resumes.
//   A stalled receiver holds the emission; the final result may wait in the
//   result register while new samples are taken.
//   Reset clears the thresholds to 310/910/310 and empties the pad window.
// ----------------------------------------------------------------------------
module three_pad_cluster_finder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [tpcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tpcf_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // sample input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tpcf_pkg::DET_W-1:0]          i_detector,
    input  logic [tpcf_pkg::ROW_W-1:0]          i_pad_row,
    input  logic [tpcf_pkg::COL_W-1:0]          i_pad_col,
    input  logic [tpcf_pkg::TB_W-1:0]           i_time_bin,
    input  logic [tpcf_pkg::ADC_W-1:0]          i_adc,
    // cluster output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [tpcf_pkg::DET_W-1:0]          o_out_detector,
    output logic [tpcf_pkg::ROW_W-1:0]          o_out_row,
    output logic [tpcf_pkg::COL_W-1:0]          o_center_col,
    output logic [tpcf_pkg::TB_W-1:0]           o_out_time_bin,
    output logic [tpcf_pkg::CLADC_W-1:0]        o_cluster_adc,
    output logic [tpcf_pkg::PSUM_W-1:0]         o_center_sum,
    output logic [tpcf_pkg::CSUM_W-1:0]         o_cluster_sum,
    output logic                                o_last
);

    tpcf_pkg::t_dp_cmd w_cmd;
    tpcf_pkg::t_dp_sts w_sts;

    // Sequencer
    tpcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath
    tpcf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_detector     (i_detector),
        .i_pad_row      (i_pad_row),
        .i_pad_col      (i_pad_col),
        .i_time_bin     (i_time_bin),
        .i_adc          (i_adc),
        .o_valid        (o_valid),
        .i_out_ready    (i_ready),
        .o_out_detector (o_out_detector),
        .o_out_row      (o_out_row),
        .o_center_col   (o_center_col),
        .o_out_time_bin (o_out_time_bin),
        .o_cluster_adc  (o_cluster_adc),
        .o_center_sum   (o_center_sum),
        .o_cluster_sum  (o_cluster_sum),
        .o_last         (o_last),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts)
    );

endmodule
